// ===== src/slr_pkg.sv =====
package slr_pkg;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_SHEAR_AXIS   = 2'd0,
      CSR_SHEAR_FACTOR = 2'd1,
      CSR_ORIGIN_X     = 2'd2,
      CSR_ORIGIN_Y     = 2'd3
   } csr_index_type;

   // Shear selector codes; the fourth code means no shear
   localparam logic [1:0] SHEAR_NONE = 2'd0;
   localparam logic [1:0] SHEAR_X    = 2'd1;
   localparam logic [1:0] SHEAR_Y    = 2'd2;

   localparam int CSR_DATA_BITS = 11;
   localparam int CSR_ADDR_BITS = 2;
   localparam int FACTOR_BITS   = 5;
   localparam int ORIGIN_RESET  = 1024;

   // Entries in the segment queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // Per-segment flags handed from the classifier to the walker
   typedef struct packed {
      logic steep;   // walk steps along y
      logic y_down;  // y decreases along the walk
      logic cut;     // segment truncated at the pixel limit
   } slr_flags_type;

endpackage

// ===== src/slr_front.sv =====
module slr_front #(
   parameter int COORD_BITS = 11,
   parameter int MAX_PIXELS = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   // segment input
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic signed [COORD_BITS-1:0]        start_x,
   input  logic signed [COORD_BITS-1:0]        start_y,
   input  logic signed [COORD_BITS-1:0]        end_x,
   input  logic signed [COORD_BITS-1:0]        end_y,
   // configuration
   input  logic [1:0]                          shear_axis,
   input  logic signed [slr_pkg::FACTOR_BITS-1:0] shear_factor,
   // classified segment toward the queue
   output logic                                out_valid,
   input  logic                                out_ready,
   output logic [COORD_BITS-1:0]               desc_x,
   output logic [COORD_BITS-1:0]               desc_y,
   output logic signed [COORD_BITS+6:0]        desc_two_dx,
   output logic signed [COORD_BITS+6:0]        desc_two_ady,
   output logic signed [COORD_BITS+7:0]        desc_d,
   output logic [$clog2(MAX_PIXELS)-1:0]       desc_cnt,
   output slr_pkg::slr_flags_type              desc_flags
);
   import slr_pkg::*;

   localparam int SW = COORD_BITS + 5;   // sheared coordinate
   localparam int DW = SW + 1;           // deltas
   localparam int EW = DW + 2;           // decision variable
   localparam int CW = $clog2(MAX_PIXELS);

   // sheared endpoints, stage 1
   logic                 s1_valid_ff, s1_valid_in;
   logic signed [SW-1:0] s1_x1_ff, s1_y1_ff, s1_x2_ff, s1_y2_ff;
   logic signed [SW-1:0] s1_x1_in, s1_y1_in, s1_x2_in, s1_y2_in;

   logic signed [SW-1:0] ex1, ey1, ex2, ey2, fac;
   logic                 load_s1, push;

   // classification of the registered endpoints
   logic                 swap, steep, cut;
   logic signed [SW-1:0] lo_x, lo_y, hi_x, hi_y;
   logic signed [DW-1:0] dx, dy, ady, major;

   assign push     = s1_valid_ff && out_ready;
   assign in_ready = !s1_valid_ff || push;
   assign load_s1  = in_valid && in_ready;

   // shear the endpoints
   always_comb begin
      ex1 = SW'(start_x);
      ey1 = SW'(start_y);
      ex2 = SW'(end_x);
      ey2 = SW'(end_y);
      fac = SW'(shear_factor);
      s1_x1_in = ex1;
      s1_y1_in = ey1;
      s1_x2_in = ex2;
      s1_y2_in = ey2;
      case (shear_axis)
         SHEAR_X: begin
            s1_x1_in = ex1 + fac * ey1;
            s1_x2_in = ex2 + fac * ey2;
         end
         SHEAR_Y: begin
            s1_y1_in = ey1 + fac * ex1;
            s1_y2_in = ey2 + fac * ex2;
         end
         default: ;
      endcase
      s1_valid_in = load_s1 ? 1'b1 : (push ? 1'b0 : s1_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_s1) begin
         s1_x1_ff <= s1_x1_in;
         s1_y1_ff <= s1_y1_in;
         s1_x2_ff <= s1_x2_in;
         s1_y2_ff <= s1_y2_in;
      end
   end

   // order by x, take deltas, pick the octant class and the initial decision
   always_comb begin
      swap = s1_x1_ff >= s1_x2_ff;
      lo_x = swap ? s1_x2_ff : s1_x1_ff;
      lo_y = swap ? s1_y2_ff : s1_y1_ff;
      hi_x = swap ? s1_x1_ff : s1_x2_ff;
      hi_y = swap ? s1_y1_ff : s1_y2_ff;
      dx    = DW'(hi_x) - DW'(lo_x);
      dy    = DW'(hi_y) - DW'(lo_y);
      ady   = dy[DW-1] ? -dy : dy;
      steep = ady > dx;
      major = steep ? ady : dx;
      cut   = major > DW'(MAX_PIXELS - 1);

      desc_x       = lo_x[COORD_BITS-1:0];
      desc_y       = lo_y[COORD_BITS-1:0];
      // doubled deltas need one bit more than the deltas
      desc_two_dx  = (DW+1)'(dx) <<< 1;
      desc_two_ady = (DW+1)'(ady) <<< 1;
      desc_d       = steep ? ((EW'(dx) <<< 1) - EW'(ady))
                           : ((EW'(ady) <<< 1) - EW'(dx));
      desc_cnt     = cut ? CW'(MAX_PIXELS - 1) : major[CW-1:0];
      desc_flags.steep  = steep;
      desc_flags.y_down = dy[DW-1];
      desc_flags.cut    = cut;
   end

   assign out_valid = s1_valid_ff;

endmodule

// ===== src/slr_queue.sv =====
module slr_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             not_full,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             not_empty,
   output logic [WIDTH-1:0] pop_data,
   output logic [$clog2(slr_pkg::QUEUE_DEPTH+1)-1:0] count
);
   import slr_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int NW = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [QUEUE_DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]    count_ff, count_in;

   assign not_full  = count_ff != NW'(QUEUE_DEPTH);
   assign not_empty = count_ff != '0;
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign count     = count_ff;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== src/slr_back.sv =====
module slr_back #(
   parameter int COORD_BITS = 11,
   parameter int MAX_PIXELS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   // classified segment from the queue
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [COORD_BITS-1:0]         desc_x,
   input  logic [COORD_BITS-1:0]         desc_y,
   input  logic signed [COORD_BITS+6:0]  desc_two_dx,
   input  logic signed [COORD_BITS+6:0]  desc_two_ady,
   input  logic signed [COORD_BITS+7:0]  desc_d,
   input  logic [$clog2(MAX_PIXELS)-1:0] desc_cnt,
   input  slr_pkg::slr_flags_type        desc_flags,
   // screen origin
   input  logic [COORD_BITS-1:0]         origin_x,
   input  logic [COORD_BITS-1:0]         origin_y,
   // pixel output
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [COORD_BITS-1:0]         pixel_col,
   output logic [COORD_BITS-1:0]         pixel_row,
   output logic                          last_pixel,
   output logic                          cut_short
);
   import slr_pkg::*;

   localparam int DW = COORD_BITS + 6;
   localparam int EW = DW + 2;
   localparam int CW = $clog2(MAX_PIXELS);

   logic                   busy_ff, busy_in;
   logic [COORD_BITS-1:0]  x_ff, x_in, y_ff, y_in;
   logic signed [EW-1:0]   d_ff, d_in;
   logic signed [EW-1:0]   two_dx_ff, two_ady_ff;
   logic [CW-1:0]          cnt_ff, cnt_in;
   slr_flags_type          flags_ff;

   logic                   out_valid_ff, out_valid_in;
   logic [COORD_BITS-1:0]  col_ff, row_ff;
   logic                   last_ff, cut_ff;

   logic                   load, fire, d_pos, step_x, step_y, done;
   logic signed [EW-1:0]   d_major, d_minor;

   assign in_ready = !busy_ff;
   assign load     = in_valid && !busy_ff;
   assign fire     = busy_ff && (!out_valid_ff || out_ready);
   assign done     = cnt_ff == '0;

   // one midpoint step per emitted pixel
   always_comb begin
      d_pos   = d_ff > 0;
      d_major = flags_ff.steep ? two_ady_ff : two_dx_ff;
      d_minor = flags_ff.steep ? two_dx_ff : two_ady_ff;
      step_x  = !flags_ff.steep || d_pos;
      step_y  = flags_ff.steep || d_pos;

      x_in    = x_ff;
      y_in    = y_ff;
      d_in    = d_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (load) begin
         x_in    = desc_x;
         y_in    = desc_y;
         d_in    = desc_d;
         cnt_in  = desc_cnt;
         busy_in = 1'b1;
      end else if (fire) begin
         x_in = step_x ? x_ff + 1'b1 : x_ff;
         if (step_y) begin
            y_in = flags_ff.y_down ? y_ff - 1'b1 : y_ff + 1'b1;
         end
         d_in   = (d_pos ? d_ff - d_major : d_ff) + d_minor;
         cnt_in = cnt_ff - 1'b1;
         busy_in = !done;
      end

      out_valid_in = fire ? 1'b1 : (out_ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // walk state and segment constants
   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      d_ff   <= d_in;
      cnt_ff <= cnt_in;
      if (load) begin
         two_dx_ff  <= EW'(desc_two_dx);
         two_ady_ff <= EW'(desc_two_ady);
         flags_ff   <= desc_flags;
      end
   end

   // output register: screen position of the current pixel
   always_ff @(posedge clock) begin
      if (fire) begin
         col_ff  <= origin_x + x_ff;
         row_ff  <= origin_y - y_ff;
         last_ff <= done;
         cut_ff  <= flags_ff.cut;
      end
   end

   assign out_valid  = out_valid_ff;
   assign pixel_col  = col_ff;
   assign pixel_row  = row_ff;
   assign last_pixel = last_ff;
   assign cut_short  = cut_ff;

endmodule

// ===== src/sheared_line_rasterizer_core.sv =====
// Channel  Direction  Handshake             Payload
// req      in         req_tvalid/tready     tdata: start_x, start_y, end_x, end_y
// rsp      out        rsp_tvalid/tready     tdata: pixel_col, pixel_row; tlast; tuser
// csr      in         csr_we (no wait)      csr_addr, csr_wdata
//
// A segment of n pixels yields min(n, MAX_PIXELS) pixels: the pixel walker loads it
// from the queue, then emits one pixel per cycle while rsp_tready does not stall it.
// The front register (shear multiply) and the 2-entry queue lie ahead of the load,
// and overlap the walk of the previous segment.
// Reset is synchronous, active high; clears handshake state, no shear, origin 1024, 1024.
// A stalled rsp_tready holds the walker; the front keeps filling the queue.
module sheared_line_rasterizer_core #(
   parameter int MAX_PIXELS = 64,
   parameter int COORD_BITS = 11
) (
   input  logic clock,
   input  logic reset,
   // segment input
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   // start_x, start_y, end_x, end_y, zero pad
   input  logic [((4*COORD_BITS+7)/8)*8-1:0]         req_tdata,
   // pixel output
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   // pixel_col, pixel_row, zero pad
   output logic [((2*COORD_BITS+7)/8)*8-1:0]         rsp_tdata,
   output logic                                      rsp_tlast,
   // cut_short
   output logic                                      rsp_tuser,
   // configuration writes
   input  logic                                      csr_we,
   input  logic [slr_pkg::CSR_ADDR_BITS-1:0]         csr_addr,
   input  logic [COORD_BITS-1:0]                     csr_wdata
);
   import slr_pkg::*;

   localparam int CB  = COORD_BITS;
   localparam int DW  = CB + 6;
   localparam int TW  = DW + 1;
   localparam int EW  = DW + 2;
   localparam int CW  = $clog2(MAX_PIXELS);
   localparam int RDW = ((2*CB+7)/8)*8;
   localparam int QW  = 2*CB + 2*TW + EW + CW + $bits(slr_flags_type);
   localparam int NW  = $clog2(QUEUE_DEPTH + 1);

   // configuration registers
   logic [1:0]                    shear_axis_ff;
   logic signed [FACTOR_BITS-1:0] shear_factor_ff;
   logic [CB-1:0]                 origin_x_ff, origin_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         shear_axis_ff   <= SHEAR_NONE;
         shear_factor_ff <= '0;
         origin_x_ff     <= CB'(ORIGIN_RESET);
         origin_y_ff     <= CB'(ORIGIN_RESET);
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_SHEAR_AXIS:   shear_axis_ff   <= csr_wdata[1:0];
            CSR_SHEAR_FACTOR: shear_factor_ff <= csr_wdata[FACTOR_BITS-1:0];
            CSR_ORIGIN_X:     origin_x_ff     <= csr_wdata;
            CSR_ORIGIN_Y:     origin_y_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // front: shear and classify
   logic                  f_valid, f_ready;
   logic [CB-1:0]         f_x, f_y;
   logic signed [TW-1:0]  f_two_dx, f_two_ady;
   logic signed [EW-1:0]  f_d;
   logic [CW-1:0]         f_cnt;
   slr_flags_type         f_flags;

   slr_front #(
      .COORD_BITS (COORD_BITS),
      .MAX_PIXELS (MAX_PIXELS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .start_x      (req_tdata[CB-1:0]),
      .start_y      (req_tdata[2*CB-1:CB]),
      .end_x        (req_tdata[3*CB-1:2*CB]),
      .end_y        (req_tdata[4*CB-1:3*CB]),
      .shear_axis   (shear_axis_ff),
      .shear_factor (shear_factor_ff),
      .out_valid    (f_valid),
      .out_ready    (f_ready),
      .desc_x       (f_x),
      .desc_y       (f_y),
      .desc_two_dx  (f_two_dx),
      .desc_two_ady (f_two_ady),
      .desc_d       (f_d),
      .desc_cnt     (f_cnt),
      .desc_flags   (f_flags)
   );

   // segment queue
   logic [QW-1:0] q_in, q_out;
   logic          q_push, q_pop, q_not_empty, b_ready;
   logic [NW-1:0] q_count;

   assign q_in   = {f_x, f_y, f_two_dx, f_two_ady, f_d, f_cnt, f_flags};
   assign q_push = f_valid && f_ready;
   assign q_pop  = q_not_empty && b_ready;

   slr_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .not_full  (f_ready),
      .push_data (q_in),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_data  (q_out),
      .count     (q_count)
   );

   logic [CB-1:0]         b_x, b_y;
   logic signed [TW-1:0]  b_two_dx, b_two_ady;
   logic signed [EW-1:0]  b_d;
   logic [CW-1:0]         b_cnt;
   slr_flags_type         b_flags;

   always_comb begin
      {b_x, b_y, b_two_dx, b_two_ady, b_d, b_cnt, b_flags} = q_out;
   end

   // back: pixel walker
   logic [CB-1:0] pix_col, pix_row;

   slr_back #(
      .COORD_BITS (COORD_BITS),
      .MAX_PIXELS (MAX_PIXELS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (q_not_empty),
      .in_ready     (b_ready),
      .desc_x       (b_x),
      .desc_y       (b_y),
      .desc_two_dx  (b_two_dx),
      .desc_two_ady (b_two_ady),
      .desc_d       (b_d),
      .desc_cnt     (b_cnt),
      .desc_flags   (b_flags),
      .origin_x     (origin_x_ff),
      .origin_y     (origin_y_ff),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .pixel_col    (pix_col),
      .pixel_row    (pix_row),
      .last_pixel   (rsp_tlast),
      .cut_short    (rsp_tuser)
   );

   assign rsp_tdata = RDW'({pix_row, pix_col});

`ifndef SYNTH
   // queue is never written when full
   assert property (@(posedge clock) disable iff (reset)
      q_push |-> (q_count < NW'(QUEUE_DEPTH)))
      else $error("segment queue overflow");

   // a segment's pixels come out without gaps
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=> rsp_tvalid)
      else $error("gap inside a segment");

   // truncation flag is the same on every pixel of a segment
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=> (rsp_tuser == $past(rsp_tuser)))
      else $error("cut flag changed inside a segment");
`endif

endmodule

// ===== dv/line_pixel_checker.sv =====
`timescale 1ns / 1ps

module line_pixel_checker #(
   parameter int MAX_PIXELS = 64,
   parameter int COORD_BITS = 11,
   parameter int REQ_BITS   = 48,
   parameter int RSP_BITS   = 24
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   // start_x, start_y, end_x, end_y, zero pad
   input  logic [REQ_BITS-1:0]                 req_tdata,
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // pixel_col, pixel_row, zero pad
   input  logic [RSP_BITS-1:0]                 rsp_tdata,
   input  logic                                rsp_tlast,
   // cut_short
   input  logic                                rsp_tuser,
   input  logic                                csr_we,
   input  logic [slr_pkg::CSR_ADDR_BITS-1:0]   csr_addr,
   input  logic [slr_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   output int                                  error_count,
   output int                                  pending
);
   import slr_pkg::*;

   // keep the log short once things go badly wrong
   localparam int PRINT_CAP = 100;

   typedef struct {
      logic [COORD_BITS-1:0] col;
      logic [COORD_BITS-1:0] row;
      logic                  last;
      logic                  cut;
   } pixel_type;

   // shadow copy of the configuration registers
   logic [1:0]                    shear_axis;
   logic signed [FACTOR_BITS-1:0] shear_factor;
   logic [COORD_BITS-1:0]         origin_x;
   logic [COORD_BITS-1:0]         origin_y;

   pixel_type expected_pixels[$];
   int        pixel_index;

   task automatic report_mismatch(input string what, input int got, input int wanted);
      if (error_count < PRINT_CAP) begin
         $display("checker: pixel %0d: %s is %0d, predicted %0d",
                  pixel_index, what, got, wanted);
      end
      error_count++;
   endtask

   // shear, order by x, then walk the doubled midpoint decision variable
   function automatic void rasterize(input logic [REQ_BITS-1:0] seg);
      int        x0, y0, x1, y1, swap, factor;
      int        dx, dy, ady, step_y, dec, px, py, count, i;
      bit        steep, cut;
      pixel_type pix;
      x0 = int'(signed'(seg[COORD_BITS-1:0]));
      y0 = int'(signed'(seg[2*COORD_BITS-1:COORD_BITS]));
      x1 = int'(signed'(seg[3*COORD_BITS-1:2*COORD_BITS]));
      y1 = int'(signed'(seg[4*COORD_BITS-1:3*COORD_BITS]));
      factor = int'(shear_factor);
      if (shear_axis == SHEAR_X) begin
         x0 += factor * y0;
         x1 += factor * y1;
      end else if (shear_axis == SHEAR_Y) begin
         y0 += factor * x0;
         y1 += factor * x1;
      end
      if (x0 >= x1) begin
         swap = x0; x0 = x1; x1 = swap;
         swap = y0; y0 = y1; y1 = swap;
      end
      dx = x1 - x0;
      dy = y1 - y0;
      step_y = (dy < 0) ? -1 : 1;
      ady = (dy < 0) ? -dy : dy;
      steep = ady > dx;
      count = (steep ? ady : dx) + 1;
      cut = count > MAX_PIXELS;
      if (cut) begin
         count = MAX_PIXELS;
      end
      dec = steep ? (2 * dx - ady) : (2 * ady - dx);
      px = x0;
      py = y0;
      for (i = 0; i < count; i++) begin
         // screen y grows downward; both coordinates wrap
         pix.col = COORD_BITS'(int'(origin_x) + px);
         pix.row = COORD_BITS'(int'(origin_y) - py);
         pix.last = (i == count - 1);
         pix.cut = cut;
         expected_pixels.push_back(pix);
         if (steep) begin
            py += step_y;
            if (dec > 0) begin
               px += 1;
               dec -= 2 * ady;
            end
            dec += 2 * dx;
         end else begin
            px += 1;
            if (dec > 0) begin
               py += step_y;
               dec -= 2 * dx;
            end
            dec += 2 * ady;
         end
      end
   endfunction

   // watch config writes, segments in and pixels out
   always @(posedge clock) begin
      pixel_type want;
      if (reset) begin
         shear_axis = SHEAR_NONE;
         shear_factor = '0;
         origin_x = COORD_BITS'(ORIGIN_RESET);
         origin_y = COORD_BITS'(ORIGIN_RESET);
         expected_pixels.delete();
         pixel_index = 0;
         error_count = 0;
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_addr))
               CSR_SHEAR_AXIS:   shear_axis = csr_wdata[1:0];
               CSR_SHEAR_FACTOR: shear_factor = csr_wdata[FACTOR_BITS-1:0];
               CSR_ORIGIN_X:     origin_x = csr_wdata[COORD_BITS-1:0];
               CSR_ORIGIN_Y:     origin_y = csr_wdata[COORD_BITS-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            rasterize(req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_pixels.size() == 0) begin
               report_mismatch("unexpected pixel, column",
                               int'(rsp_tdata[COORD_BITS-1:0]), -1);
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_tdata[COORD_BITS-1:0] !== want.col) begin
                  report_mismatch("pixel_col", int'(rsp_tdata[COORD_BITS-1:0]),
                                  int'(want.col));
               end
               if (rsp_tdata[2*COORD_BITS-1:COORD_BITS] !== want.row) begin
                  report_mismatch("pixel_row", int'(rsp_tdata[2*COORD_BITS-1:COORD_BITS]),
                                  int'(want.row));
               end
               if (rsp_tlast !== want.last) begin
                  report_mismatch("last_pixel", int'(rsp_tlast), int'(want.last));
               end
               if (rsp_tuser !== want.cut) begin
                  report_mismatch("cut_short", int'(rsp_tuser), int'(want.cut));
               end
            end
            pixel_index++;
         end
      end
      pending <= expected_pixels.size();
   end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import slr_pkg::*;

   localparam int MAX_PIXELS  = 64;
   localparam int COORD_BITS  = 11;
   localparam int REQ_BITS    = ((4 * COORD_BITS + 7) / 8) * 8;
   localparam int RSP_BITS    = ((2 * COORD_BITS + 7) / 8) * 8;
   localparam int CMIN        = -(1 << (COORD_BITS - 1));
   localparam int CMAX        = (1 << (COORD_BITS - 1)) - 1;
   localparam int STALL_PCT   = 73;
   localparam int BOTH_PCT    = 9;
   localparam int HOLD_CYCLES = 400;
   localparam int IDLE_LIMIT  = 3000;
   localparam int PHASE_ITEMS = 39;
   // fourth selector code, not named in the package; acts as no shear
   localparam logic [1:0] SHEAR_UNUSED = 2'd3;

   typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [REQ_BITS-1:0]        req_tdata = '0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [RSP_BITS-1:0]        rsp_tdata;
   logic                       rsp_tlast;
   logic                       rsp_tuser;
   logic                       csr_we = 1'b0;
   logic [CSR_ADDR_BITS-1:0]   csr_addr = '0;
   logic [CSR_DATA_BITS-1:0]   csr_wdata = '0;

   idle_mode_type idle_mode = IDLE_NONE;
   bit            pressure_on = 1'b0;
   bit            hold_done = 1'b0;
   int            hold_left = 0;
   int            idle_cycles = 0;
   int            error_count;
   int            pending;

   sheared_line_rasterizer_core #(
      .MAX_PIXELS(MAX_PIXELS),
      .COORD_BITS(COORD_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .rsp_tuser(rsp_tuser),
      .csr_we(csr_we),
      .csr_addr(csr_addr),
      .csr_wdata(csr_wdata)
   );

   line_pixel_checker #(
      .MAX_PIXELS(MAX_PIXELS),
      .COORD_BITS(COORD_BITS),
      .REQ_BITS(REQ_BITS),
      .RSP_BITS(RSP_BITS)
   ) pixel_checker (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .rsp_tuser(rsp_tuser),
      .csr_we(csr_we),
      .csr_addr(csr_addr),
      .csr_wdata(csr_wdata),
      .error_count(error_count),
      .pending(pending)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic int stall_pct(input idle_mode_type mode, input bit sender);
      case (mode)
         IDLE_SEND: return sender ? STALL_PCT : 0;
         IDLE_RECV: return sender ? 0 : STALL_PCT;
         IDLE_BOTH: return BOTH_PCT;
         default:   return 0;
      endcase
   endfunction

   function automatic int coord_in(input int lo, input int hi);
      return lo + int'($urandom_range(hi - lo));
   endfunction

   // pixel receiver: random stalls, plus one long hold-off in the pressure phase
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (pressure_on && !hold_done) begin
         rsp_tready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct(idle_mode, 1'b0));
      end
   end

   // watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   task automatic send_segment(input int sx, input int sy, input int ex, input int ey);
      int gap;
      gap = 0;
      while (gap < 60 && $urandom_range(99) < stall_pct(idle_mode, 1'b1)) begin
         gap++;
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= REQ_BITS'({COORD_BITS'(ey), COORD_BITS'(ex),
                              COORD_BITS'(sy), COORD_BITS'(sx)});
      do @(posedge clock); while (!req_tready);
   endtask

   // all four registers back to back; spare bits of the narrow ones get noise
   task automatic write_config(input logic [1:0] axis, input int factor,
                               input int ox, input int oy);
      csr_we <= 1'b1;
      csr_addr <= CSR_SHEAR_AXIS;
      csr_wdata <= {(CSR_DATA_BITS - 2)'($urandom), axis};
      @(posedge clock);
      csr_addr <= CSR_SHEAR_FACTOR;
      csr_wdata <= {(CSR_DATA_BITS - FACTOR_BITS)'($urandom), FACTOR_BITS'(factor)};
      @(posedge clock);
      csr_addr <= CSR_ORIGIN_X;
      csr_wdata <= CSR_DATA_BITS'(ox);
      @(posedge clock);
      csr_addr <= CSR_ORIGIN_Y;
      csr_wdata <= CSR_DATA_BITS'(oy);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_drain();
      @(posedge clock);
      while (pending != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   // mix of segment shapes; near-limit ones straddle the pixel cap
   task automatic random_segment(output int sx, output int sy, output int ex, output int ey);
      int kind, major, minor, ddx, ddy;
      kind = $urandom_range(99);
      if (kind < 5) begin
         sx = coord_in(CMIN, CMAX);
         sy = coord_in(CMIN, CMAX);
         ex = sx;
         ey = sy;
      end else if (kind < 40) begin
         sx = coord_in(CMIN + 45, CMAX - 45);
         sy = coord_in(CMIN + 45, CMAX - 45);
         ex = sx + coord_in(-40, 40);
         ey = sy + coord_in(-40, 40);
      end else if (kind < 65) begin
         major = coord_in(61, 66);
         minor = coord_in(0, major);
         if ($urandom_range(1)) begin
            ddx = minor;
            ddy = major;
         end else begin
            ddx = major;
            ddy = minor;
         end
         if ($urandom_range(1)) ddx = -ddx;
         if ($urandom_range(1)) ddy = -ddy;
         sx = coord_in(CMIN + 70, CMAX - 70);
         sy = coord_in(CMIN + 70, CMAX - 70);
         ex = sx + ddx;
         ey = sy + ddy;
      end else if (kind < 80) begin
         sx = coord_in(-20, 20);
         sy = coord_in(-20, 20);
         ex = coord_in(-20, 20);
         ey = coord_in(-20, 20);
      end else begin
         sx = coord_in(CMIN, CMAX);
         sy = coord_in(CMIN, CMAX);
         ex = coord_in(CMIN, CMAX);
         ey = coord_in(CMIN, CMAX);
      end
   endtask

   task automatic run_phase(input logic [1:0] axis, input int factor, input int ox,
                            input int oy, input idle_mode_type mode, input bit pressure);
      int sx, sy, ex, ey;
      write_config(axis, factor, ox, oy);
      idle_mode <= mode;
      if (pressure) begin
         pressure_on <= 1'b1;
      end
      repeat (PHASE_ITEMS) begin
         random_segment(sx, sy, ex, ey);
         send_segment(sx, sy, ex, ey);
      end
      req_tvalid <= 1'b0;
      wait_drain();
   endtask

   // stimulus and verdict
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed segments under reset configuration
      send_segment(0, 0, 0, 0);
      send_segment(CMIN, CMIN, CMIN, CMIN);
      send_segment(CMAX, CMAX, CMAX, CMAX);
      send_segment(5, -3, 5, 10);
      send_segment(5, 10, 5, -3);
      send_segment(-10, 0, 20, 0);
      send_segment(20, 0, -10, 0);
      send_segment(0, 0, 30, 12);
      send_segment(0, 0, 30, -12);
      send_segment(30, 12, 0, 0);
      send_segment(0, 0, 20, 20);
      send_segment(0, 0, 20, -20);
      send_segment(0, 0, 5, 40);
      send_segment(0, 0, -5, 40);
      send_segment(0, 0, 63, 0);
      send_segment(0, 0, 64, 0);
      send_segment(0, 0, 7, 63);
      send_segment(0, 64, 7, 0);
      send_segment(CMIN, CMIN, CMAX, CMAX);
      send_segment(CMIN, CMAX, CMAX, CMIN);
      send_segment(CMAX, CMIN, CMIN, CMAX);
      send_segment(CMIN, CMIN, CMIN + 3, CMIN);
      send_segment(CMAX, CMAX, CMAX - 3, CMAX);
      req_tvalid <= 1'b0;
      wait_drain();

      run_phase(SHEAR_X, 8, 0, 0, IDLE_NONE, 1'b0);
      run_phase(SHEAR_Y, -8, 2047, 2047, IDLE_SEND, 1'b0);
      run_phase(SHEAR_X, -16, coord_in(0, 2047), coord_in(0, 2047), IDLE_RECV, 1'b0);
      run_phase(SHEAR_Y, 15, ORIGIN_RESET, ORIGIN_RESET, IDLE_BOTH, 1'b0);
      run_phase(SHEAR_UNUSED, coord_in(-16, 15), 0, 2047, IDLE_NONE, 1'b1);
      run_phase(SHEAR_NONE, 0, 2047, 0, IDLE_RECV, 1'b0);
      run_phase(2'($urandom_range(3)), coord_in(-16, 15), coord_in(0, 2047),
                coord_in(0, 2047), IDLE_SEND, 1'b0);
      run_phase(SHEAR_X, 1, ORIGIN_RESET, ORIGIN_RESET, IDLE_BOTH, 1'b0);
      run_phase(SHEAR_Y, coord_in(-16, 15), coord_in(0, 2047), coord_in(0, 2047),
                IDLE_NONE, 1'b0);

      repeat (MAX_PIXELS + 8) @(posedge clock);
      if (error_count == 0 && pending == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
